// ----- rtl/utr_pkg.sv -----
// Package for unsigned_to_radix_text: widths, radix codes, FSM state, item types
// and the digit-to-ASCII lookup. No dependencies.
`default_nettype none

package utr_pkg;

  localparam int VALUE_BITS = 32;
  localparam int VALUE_W    = 32;
  localparam int RADIX_W    = 2;
  localparam int CHAR_W     = 7;
  localparam int DIGIT_W    = 4;
  localparam int IDX_W      = $clog2(VALUE_BITS);

  localparam logic [RADIX_W-1:0] RADIX_BIN = 2'd0;
  localparam logic [RADIX_W-1:0] RADIX_DEC = 2'd1;
  localparam logic [RADIX_W-1:0] RADIX_HEX = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXTRACT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [RADIX_W-1:0] radix_code;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } out_item_t;

  // one digit handed from the extractor to the top level
  typedef struct packed {
    logic               valid;
    logic [DIGIT_W-1:0] digit;
    logic               final_digit;
  } digit_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    case (d)
      4'd10:   c = 7'h41;
      4'd11:   c = 7'h42;
      4'd12:   c = 7'h43;
      4'd13:   c = 7'h44;
      4'd14:   c = 7'h45;
      4'd15:   c = 7'h46;
      default: c = 7'h30 + CHAR_W'(d);
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/utr_div.sv -----
// Digit extractor: repeated remainder/quotient by 2, 10 or 16, least significant first.
// Decimal uses a bit-serial restoring divider by ten. Depends on utr_pkg.
`default_nettype none

module utr_div (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire logic [utr_pkg::VALUE_W-1:0]     value,
  input  wire logic [utr_pkg::RADIX_W-1:0]     radix_code,
  output utr_pkg::digit_t                      dig
);

  localparam int VB = utr_pkg::VALUE_BITS;

  logic                          busy_r, busy_nxt;
  logic [VB-1:0]                 q_r, q_nxt;
  logic [utr_pkg::DIGIT_W-1:0]   rem_r, rem_nxt;
  logic [utr_pkg::IDX_W-1:0]     bit_cnt_r, bit_cnt_nxt;
  logic [utr_pkg::RADIX_W-1:0]   radix_r, radix_nxt;

  logic [utr_pkg::DIGIT_W:0]     trial;
  logic                          ge_ten;
  logic [utr_pkg::DIGIT_W-1:0]   rem_step;

  // one restoring-division step by ten
  assign trial    = {rem_r, q_r[VB-1]};
  assign ge_ten   = (trial >= 5'd10);
  assign rem_step = ge_ten ? 4'(trial - 5'd10) : trial[utr_pkg::DIGIT_W-1:0];

  always_comb begin
    busy_nxt    = busy_r;
    q_nxt       = q_r;
    rem_nxt     = rem_r;
    bit_cnt_nxt = bit_cnt_r;
    radix_nxt   = radix_r;
    dig         = '0;
    if (start) begin
      busy_nxt    = 1'b1;
      q_nxt       = VB'(value);
      rem_nxt     = '0;
      bit_cnt_nxt = '0;
      radix_nxt   = radix_code;
    end else if (busy_r) begin
      case (radix_r)
        utr_pkg::RADIX_BIN: begin
          q_nxt           = q_r >> 1;
          dig.valid       = 1'b1;
          dig.digit       = {3'b000, q_r[0]};
          dig.final_digit = (q_nxt == '0);
        end
        utr_pkg::RADIX_DEC: begin
          q_nxt       = {q_r[VB-2:0], ge_ten};
          rem_nxt     = rem_step;
          bit_cnt_nxt = bit_cnt_r + 1'b1;
          if (bit_cnt_r == utr_pkg::IDX_W'(VB - 1)) begin
            dig.valid       = 1'b1;
            dig.digit       = rem_step;
            dig.final_digit = (q_nxt == '0);
            rem_nxt         = '0;
            bit_cnt_nxt     = '0;
          end
        end
        default: begin
          // hex, and the unused code
          q_nxt           = q_r >> 4;
          dig.valid       = 1'b1;
          dig.digit       = q_r[3:0];
          dig.final_digit = (q_nxt == '0);
        end
      endcase
      if (dig.valid && dig.final_digit) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    q_r       <= q_nxt;
    rem_r     <= rem_nxt;
    bit_cnt_r <= bit_cnt_nxt;
    radix_r   <= radix_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/unsigned_to_radix_text.sv -----
// Top level of the radix-to-ASCII converter: control FSM, digit store and output
// register. Depends on utr_pkg and utr_div.
`default_nettype none

// Converts an unsigned VALUE_BITS-bit number to ASCII text in binary, decimal or
// hexadecimal (codes 0, 1, 2; code 3 acts as hex), most significant character
// first, uppercase A-F, no leading zeros, zero gives "0", last set on the final
// character. One number is handled at a time: in_stall is high from acceptance
// until the final character has been loaded into the output register. Digit
// extraction yields one digit per cycle for binary and hex; for decimal, each digit
// comes from the bit-serial divide-by-ten, which steps through all VALUE_BITS
// (32) bits of the quotient. Characters then leave one per cycle while out_stall
// is low. The next number is taken while the final character still waits in
// the output register. No clearing pass follows reset.
module unsigned_to_radix_text (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output      logic                in_stall,
  input  wire utr_pkg::in_item_t   in_item,
  output      logic                out_valid,
  input  wire logic                out_stall,
  output      utr_pkg::out_item_t  out_item
);

  localparam int VB = utr_pkg::VALUE_BITS;

  utr_pkg::state_t state_r, state_nxt;

  logic [utr_pkg::DIGIT_W-1:0] store_r [VB];
  logic [utr_pkg::IDX_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [utr_pkg::IDX_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic                        out_valid_r, out_valid_nxt;
  utr_pkg::out_item_t          out_item_r, out_item_nxt;

  logic            accept;
  logic            load_out;
  utr_pkg::digit_t dig;

  utr_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (accept),
    .value      (in_item.value),
    .radix_code (in_item.radix_code),
    .dig        (dig)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      utr_pkg::ST_IDLE:    if (accept) state_nxt = utr_pkg::ST_EXTRACT;
      utr_pkg::ST_EXTRACT: if (dig.valid && dig.final_digit) state_nxt = utr_pkg::ST_EMIT;
      utr_pkg::ST_EMIT:    if (load_out && rd_idx_r == '0) state_nxt = utr_pkg::ST_IDLE;
      default:             state_nxt = utr_pkg::ST_IDLE;
    endcase
  end

  // outputs of the FSM
  always_comb begin
    in_stall = 1'b1;
    load_out = 1'b0;
    case (state_r)
      utr_pkg::ST_IDLE: in_stall = 1'b0;
      utr_pkg::ST_EMIT: load_out = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  assign accept = in_valid && !in_stall;

  always_comb begin
    wr_ptr_nxt    = wr_ptr_r;
    rd_idx_nxt    = rd_idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    if (accept) wr_ptr_nxt = '0;
    if (dig.valid) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
      // the most significant digit sits at the current write slot
      if (dig.final_digit) rd_idx_nxt = wr_ptr_r;
    end
    if (load_out) begin
      out_valid_nxt          = 1'b1;
      out_item_nxt.character = utr_pkg::digit_char(store_r[rd_idx_r]);
      out_item_nxt.last      = (rd_idx_r == '0);
      rd_idx_nxt             = rd_idx_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= utr_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    wr_ptr_r   <= wr_ptr_nxt;
    rd_idx_r   <= rd_idx_nxt;
    out_item_r <= out_item_nxt;
    if (dig.valid) store_r[wr_ptr_r] <= dig.digit;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // digits only arrive while extracting
  a_digit_in_extract: assert property (@(posedge clk) disable iff (!rst_n)
    dig.valid |-> state_r == utr_pkg::ST_EXTRACT)
    else $error("digit produced outside extraction");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == utr_pkg::ST_EXTRACT)
    else $error("accepted item did not start extraction");

  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_item.character >= 7'h30 && out_item.character <= 7'h39) ||
                   (out_item.character >= 7'h41 && out_item.character <= 7'h46)))
    else $error("character out of range");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && rd_idx_r == '0) |=> out_item.last && state_r == utr_pkg::ST_IDLE)
    else $error("final character not marked or run not ended");

endmodule

`default_nettype wire
